[design/rec_pkg.sv]
// Shared constants, types and helpers for the regional extrema counter.
// No dependencies; compiled first.
`default_nettype none

package rec_pkg;

  localparam int SIDE_MAX    = 64;
  localparam int HEIGHT_BITS = 16;
  localparam int CELLS_MAX   = SIDE_MAX * SIDE_MAX;
  localparam int IDX_W       = $clog2(CELLS_MAX);
  localparam int CNT_W       = IDX_W + 1;
  localparam int POS_W       = $clog2(SIDE_MAX);
  localparam int SIDE_W      = 7;
  localparam int COUNT_W     = 13;

  // Sequencer states
  typedef enum logic [4:0] {
    S_LOAD, S_U_CELL, S_U_HP, S_U_NB, S_U_HQ, S_FIND, S_U_LINK, S_U_COMP,
    S_E_CELL, S_E_HP, S_E_NB, S_E_HQ, S_E_FRD, S_E_FWR,
    S_C_RD, S_C_CHK, S_DONE
  } state_e;

  // One neighbor step as direction flags
  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } dir_t;

  // Neighbor order: the first four point back in raster order
  function automatic dir_t dir_of(input logic [2:0] k);
    dir_t d;
    d = '0;
    case (k)
      3'd0: d.lf = 1'b1;
      3'd1: begin d.up = 1'b1; d.lf = 1'b1; end
      3'd2: d.up = 1'b1;
      3'd3: begin d.up = 1'b1; d.rt = 1'b1; end
      3'd4: d.rt = 1'b1;
      3'd5: begin d.dn = 1'b1; d.lf = 1'b1; end
      3'd6: d.dn = 1'b1;
      default: begin d.dn = 1'b1; d.rt = 1'b1; end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

[design/rec_cell_if.sv]
// Input channel: one grid cell height per beat.
// Depends on rec_pkg.
`default_nettype none

interface rec_cell_if;
  import rec_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [HEIGHT_BITS-1:0] height;
  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

`default_nettype wire

[design/rec_count_if.sv]
// Output channel: peak and pit counts, one beat per grid.
// Depends on rec_pkg.
`default_nettype none

interface rec_count_if;
  import rec_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] peak_count;
  logic [COUNT_W-1:0] pit_count;
  modport source (output valid, output peak_count, output pit_count, input ready);
  modport sink (input valid, input peak_count, input pit_count, output ready);
endinterface

`default_nettype wire

[design/regional_extrema_counter.sv]
// Regional extrema counter top level: load, union-find, flag and count passes.
// Depends on rec_pkg, rec_cell_if, rec_count_if.
//
// Usage: write side_size_i (1..64, 0 acts as 1, above 64 acts as 64) with
// side_size_we_i while idle; this also restarts the grid being loaded.
// Feed side*side heights on cell_i in raster order; cell_i takes one beat per
// cycle while loading. After the last cell the block runs three passes over
// its memories and accepts nothing. The first pass joins equal 8-connected back
// neighbors: per cell it reads the height, skips missing neighbors, compares
// each present one and, if equal, finds its root by walking links, hangs that
// root under the cell and compresses the neighbor. The second pass sets
// per-root peak/pit flags: it walks from each cell to its root, clears the
// flags against every present neighbor and merges them into the root's flags.
// The third pass counts roots by flag. Find walks grow with the side on wide plateaus. One beat on count_o then
// carries both counts. The result register holds until count_o.ready; loading
// of the next grid goes on meanwhile, and a finished grid waits for the
// register to free.
// Reset sets the side to 64 and empties the grid; no clearing pass is needed,
// since each cell's link and flags are initialized as the cell loads.
`default_nettype none

module regional_extrema_counter (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           side_size_we_i,
  input  wire [rec_pkg::SIDE_W-1:0]     side_size_i,
  rec_cell_if.sink                      cell_i,
  rec_count_if.source                   count_o
);
  import rec_pkg::*;

  // Memories
  logic [HEIGHT_BITS-1:0] h_mem [CELLS_MAX];
  logic [IDX_W-1:0]       link_mem [CELLS_MAX];
  logic [1:0]             flg_mem [CELLS_MAX];

  logic [HEIGHT_BITS-1:0] h_rd_q;
  logic [IDX_W-1:0]       link_rd_q;
  logic [1:0]             flg_rd_q;

  logic [IDX_W-1:0]       h_raddr, link_raddr, flg_raddr;
  logic                   h_we, link_we, flg_we;
  logic [IDX_W-1:0]       h_waddr, link_waddr, flg_waddr;
  logic [HEIGHT_BITS-1:0] h_wdata;
  logic [IDX_W-1:0]       link_wdata;
  logic [1:0]             flg_wdata;

  // Control and data registers
  state_e               state_q, state_d;
  logic [SIDE_W-1:0]    side_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     p_q, p_d;
  logic [POS_W-1:0]     r_q, r_d, c_q, c_d;
  logic [2:0]           k_q, k_d;
  logic [IDX_W-1:0]     fx_q, fx_d;
  logic [HEIGHT_BITS-1:0] hp_q, hp_d;
  logic [1:0]           acc_q, acc_d;
  logic                 phase_q, phase_d;
  logic [COUNT_W-1:0]   peak_q, peak_d, pit_q, pit_d;
  logic                 out_valid_q, out_valid_d;
  logic [COUNT_W-1:0]   out_peak_q, out_peak_d, out_pit_q, out_pit_d;

  // Grid geometry
  logic [SIDE_W-1:0]    n_eff;
  logic [POS_W-1:0]     n_m1;
  logic [CNT_W-1:0]     total;
  logic [IDX_W-1:0]     last_idx;
  dir_t                 dir;
  logic                 nb_ok;
  logic [CNT_W-1:0]     q_wide;
  logic [IDX_W-1:0]     q_idx;
  logic                 cell_last;
  logic                 in_beat;

  always_comb begin
    if (side_q == '0) begin
      n_eff = SIDE_W'(1);
    end else if (side_q > SIDE_W'(SIDE_MAX)) begin
      n_eff = SIDE_W'(SIDE_MAX);
    end else begin
      n_eff = side_q;
    end
  end

  assign n_m1      = POS_W'(n_eff - SIDE_W'(1));
  assign total     = CNT_W'(n_eff) * CNT_W'(n_eff);
  assign last_idx  = IDX_W'(total - CNT_W'(1));
  assign cell_last = (p_q == last_idx);

  // Neighbor address and bounds
  assign dir   = dir_of(k_q);
  assign nb_ok = !(dir.up && r_q == '0) && !(dir.dn && r_q == n_m1) &&
                 !(dir.lf && c_q == '0) && !(dir.rt && c_q == n_m1);
  assign q_wide = CNT_W'(p_q) + (dir.dn ? CNT_W'(n_eff) : '0) -
                  (dir.up ? CNT_W'(n_eff) : '0) + CNT_W'(dir.rt) - CNT_W'(dir.lf);
  assign q_idx  = q_wide[IDX_W-1:0];

  assign in_beat = cell_i.valid && cell_i.ready;
  assign cell_i.ready = (state_q == S_LOAD);

  assign count_o.valid      = out_valid_q;
  assign count_o.peak_count = out_peak_q;
  assign count_o.pit_count  = out_pit_q;

  // Memory ports: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h_mem[h_waddr] <= h_wdata;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (flg_we) begin
      flg_mem[flg_waddr] <= flg_wdata;
    end
    h_rd_q    <= h_mem[h_raddr];
    link_rd_q <= link_mem[link_raddr];
    flg_rd_q  <= flg_mem[flg_raddr];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      side_q      <= SIDE_W'(SIDE_MAX);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      if (side_size_we_i) begin
        side_q <= side_size_i;
        cnt_q  <= '0;
      end else begin
        cnt_q  <= cnt_d;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    r_q        <= r_d;
    c_q        <= c_d;
    k_q        <= k_d;
    fx_q       <= fx_d;
    hp_q       <= hp_d;
    acc_q      <= acc_d;
    peak_q     <= peak_d;
    pit_q      <= pit_d;
    out_peak_q <= out_peak_d;
    out_pit_q  <= out_pit_d;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    p_d         = p_q;
    r_d         = r_q;
    c_d         = c_q;
    k_d         = k_q;
    fx_d        = fx_q;
    hp_d        = hp_q;
    acc_d       = acc_q;
    phase_d     = phase_q;
    peak_d      = peak_q;
    pit_d       = pit_q;
    out_valid_d = out_valid_q && !count_o.ready;
    out_peak_d  = out_peak_q;
    out_pit_d   = out_pit_q;

    h_raddr    = p_q;
    link_raddr = p_q;
    flg_raddr  = p_q;
    h_we       = 1'b0;
    h_waddr    = cnt_q[IDX_W-1:0];
    h_wdata    = cell_i.height;
    link_we    = 1'b0;
    link_waddr = cnt_q[IDX_W-1:0];
    link_wdata = cnt_q[IDX_W-1:0];
    flg_we     = 1'b0;
    flg_waddr  = cnt_q[IDX_W-1:0];
    flg_wdata  = 2'b11;

    unique case (state_q)
      // Store the cell and make it a root with both flags set
      S_LOAD: begin
        if (in_beat) begin
          h_we    = 1'b1;
          link_we = 1'b1;
          flg_we  = 1'b1;
          if (cnt_q + CNT_W'(1) >= total) begin
            cnt_d   = '0;
            p_d     = '0;
            r_d     = '0;
            c_d     = '0;
            phase_d = 1'b0;
            state_d = S_U_CELL;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      S_U_CELL: begin
        h_raddr = p_q;
        state_d = S_U_HP;
      end
      S_U_HP: begin
        hp_d    = h_rd_q;
        k_d     = '0;
        state_d = S_U_NB;
      end
      // Look at the back neighbors
      S_U_NB: begin
        if (nb_ok) begin
          h_raddr = q_idx;
          state_d = S_U_HQ;
        end else if (k_q == 3'd3) begin
          if (cell_last) begin
            p_d     = '0;
            r_d     = '0;
            c_d     = '0;
            phase_d = 1'b1;
            state_d = S_E_CELL;
          end else begin
            p_d     = p_q + IDX_W'(1);
            c_d     = (c_q == n_m1) ? '0 : c_q + POS_W'(1);
            r_d     = (c_q == n_m1) ? r_q + POS_W'(1) : r_q;
            state_d = S_U_CELL;
          end
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      S_U_HQ: begin
        if (h_rd_q == hp_q) begin
          link_raddr = q_idx;
          fx_d       = q_idx;
          state_d    = S_FIND;
        end else if (k_q == 3'd3) begin
          // Unequal last back neighbor: advance to the next cell, or to the flag pass after the last cell
          if (cell_last) begin
            p_d     = '0;
            r_d     = '0;
            c_d     = '0;
            phase_d = 1'b1;
            state_d = S_E_CELL;
          end else begin
            p_d     = p_q + IDX_W'(1);
            c_d     = (c_q == n_m1) ? '0 : c_q + POS_W'(1);
            r_d     = (c_q == n_m1) ? r_q + POS_W'(1) : r_q;
            state_d = S_U_CELL;
          end
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_U_NB;
        end
      end
      // Walk links up to the root
      S_FIND: begin
        if (link_rd_q == fx_q) begin
          if (phase_q) begin
            k_d     = '0;
            acc_d   = 2'b11;
            state_d = S_E_NB;
          end else begin
            state_d = S_U_LINK;
          end
        end else begin
          fx_d       = link_rd_q;
          link_raddr = link_rd_q;
        end
      end
      // Hang the neighbor's root under the current cell
      S_U_LINK: begin
        link_we    = 1'b1;
        link_waddr = fx_q;
        link_wdata = p_q;
        state_d    = S_U_COMP;
      end
      // Compress the neighbor, then move on
      S_U_COMP: begin
        if (nb_ok && hp_q == h_rd_q) begin
          link_we    = 1'b1;
          link_waddr = q_idx;
          link_wdata = p_q;
        end
        if (k_q == 3'd3) begin
          if (cell_last) begin
            p_d     = '0;
            r_d     = '0;
            c_d     = '0;
            phase_d = 1'b1;
            state_d = S_E_CELL;
          end else begin
            p_d     = p_q + IDX_W'(1);
            c_d     = (c_q == n_m1) ? '0 : c_q + POS_W'(1);
            r_d     = (c_q == n_m1) ? r_q + POS_W'(1) : r_q;
            state_d = S_U_CELL;
          end
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_U_NB;
        end
      end
      S_E_CELL: begin
        h_raddr = p_q;
        state_d = S_E_HP;
      end
      S_E_HP: begin
        hp_d       = h_rd_q;
        link_raddr = p_q;
        fx_d       = p_q;
        state_d    = S_FIND;
      end
      S_E_NB: begin
        if (nb_ok) begin
          h_raddr = q_idx;
          state_d = S_E_HQ;
        end else if (k_q == 3'd7) begin
          state_d = S_E_FRD;
        end else begin
          k_d = k_q + 3'd1;
        end
      end
      // Clear flags against one neighbor
      S_E_HQ: begin
        if (hp_q < h_rd_q) begin
          acc_d[1] = 1'b0;
        end
        if (hp_q > h_rd_q) begin
          acc_d[0] = 1'b0;
        end
        if (k_q == 3'd7) begin
          state_d = S_E_FRD;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_E_NB;
        end
      end
      S_E_FRD: begin
        flg_raddr = fx_q;
        state_d   = S_E_FWR;
      end
      // Merge this cell's flags into its root
      S_E_FWR: begin
        flg_we    = 1'b1;
        flg_waddr = fx_q;
        flg_wdata = flg_rd_q & acc_q;
        if (cell_last) begin
          p_d     = '0;
          peak_d  = '0;
          pit_d   = '0;
          state_d = S_C_RD;
        end else begin
          p_d     = p_q + IDX_W'(1);
          c_d     = (c_q == n_m1) ? '0 : c_q + POS_W'(1);
          r_d     = (c_q == n_m1) ? r_q + POS_W'(1) : r_q;
          state_d = S_E_CELL;
        end
      end
      S_C_RD: begin
        link_raddr = p_q;
        flg_raddr  = p_q;
        state_d    = S_C_CHK;
      end
      // Count roots by flag
      S_C_CHK: begin
        if (link_rd_q == p_q) begin
          peak_d = peak_q + COUNT_W'(flg_rd_q[1]);
          pit_d  = pit_q + COUNT_W'(flg_rd_q[0]);
        end
        if (cell_last) begin
          state_d = S_DONE;
        end else begin
          p_d     = p_q + IDX_W'(1);
          state_d = S_C_RD;
        end
      end
      // Hand over once the result register is free
      S_DONE: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          out_peak_d  = peak_q;
          out_pit_d   = pit_q;
          state_d     = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

endmodule

`default_nettype wire
